[design/irpd_pkg.sv]
package irpd_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned BitPosW   = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  // Edge positions inside one frame
  localparam logic [IdxW-1:0] FRAME_LAST_EDGE = IdxW'(32);
  localparam logic [IdxW-1:0] ADDR_FIRST      = IdxW'(3);
  localparam logic [IdxW-1:0] ADDR_LAST       = IdxW'(10);
  localparam logic [IdxW-1:0] CMD_FIRST       = IdxW'(19);
  localparam logic [IdxW-1:0] CMD_LAST        = IdxW'(26);

  // Register reset values
  localparam logic [IntervalW-1:0] GAP_THRESHOLD_RST = IntervalW'(3000);
  localparam logic [ByteW-1:0]     BIT_THRESHOLD_RST = ByteW'(54);

  // Register index, taken from paddr[2]
  localparam logic REG_GAP_THRESHOLD = 1'b0;
  localparam logic REG_BIT_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [IntervalW-1:0] gap_threshold;
    logic [ByteW-1:0]     bit_threshold;
  } cfg_t;

endpackage

[design/irpd_if.sv]
interface irpd_edge_if;
  logic                            valid;
  logic                            ready;
  logic [irpd_pkg::IntervalW-1:0]  edge_interval;

  modport source (output valid, output edge_interval, input ready);
  modport sink   (input valid, input edge_interval, output ready);
endinterface

interface irpd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_done;
  logic [irpd_pkg::ByteW-1:0]  command_code;
  logic [irpd_pkg::ByteW-1:0]  device_address;

  modport source (output valid, output frame_done, output command_code,
                  output device_address, input ready);
  modport sink   (input valid, input frame_done, input command_code,
                  input device_address, output ready);
endinterface

[design/irpd_cfg_regs.sv]
module irpd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [irpd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [irpd_pkg::ApbDataW-1:0]  pwdata,
  output logic [irpd_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output irpd_pkg::cfg_t                 cfg_o
);

  irpd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // registers sit on 4-byte boundaries; low address bits are don't-care
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_threshold <= irpd_pkg::GAP_THRESHOLD_RST;
      cfg_q.bit_threshold <= irpd_pkg::BIT_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        irpd_pkg::REG_GAP_THRESHOLD:
          cfg_q.gap_threshold <= pwdata[irpd_pkg::IntervalW-1:0];
        irpd_pkg::REG_BIT_THRESHOLD:
          cfg_q.bit_threshold <= pwdata[irpd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      irpd_pkg::REG_GAP_THRESHOLD:
        prdata = irpd_pkg::ApbDataW'(cfg_q.gap_threshold);
      irpd_pkg::REG_BIT_THRESHOLD:
        prdata = irpd_pkg::ApbDataW'(cfg_q.bit_threshold);
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/irpd_decode.sv]
module irpd_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irpd_pkg::cfg_t        cfg_i,
  irpd_edge_if.sink             edge_i,
  irpd_result_if.source         result_o
);

  // input stage
  logic                              in_valid_q;
  logic [irpd_pkg::IntervalW-1:0]    interval_q;
  logic                              advance;

  // frame state
  logic [irpd_pkg::IdxW-1:0]   edge_index_q, edge_index_d;
  logic [irpd_pkg::ByteW-1:0]  addr_q, addr_d;
  logic [irpd_pkg::ByteW-1:0]  cmd_q, cmd_d;

  // result stage
  logic                        out_valid_q;
  logic                        done_q, done_d;
  logic [irpd_pkg::ByteW-1:0]  cmd_out_q, cmd_out_d;
  logic [irpd_pkg::ByteW-1:0]  addr_out_q, addr_out_d;

  logic [irpd_pkg::IdxW-1:0]    idx;
  logic [irpd_pkg::IdxW-1:0]    addr_off;
  logic [irpd_pkg::IdxW-1:0]    cmd_off;
  logic                         bit_one;
  logic                         in_addr;
  logic                         in_cmd;

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign edge_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (edge_i.ready) begin
      in_valid_q <= edge_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_i.valid && edge_i.ready) begin
      interval_q <= edge_i.edge_interval;
    end
  end

  always_comb begin
    // a long gap restarts the frame before this edge is placed
    idx      = (interval_q >= cfg_i.gap_threshold) ? '0 : edge_index_q;
    bit_one  = interval_q[irpd_pkg::ByteW-1:0] > cfg_i.bit_threshold;
    in_addr  = (idx >= irpd_pkg::ADDR_FIRST) && (idx <= irpd_pkg::ADDR_LAST);
    in_cmd   = (idx >= irpd_pkg::CMD_FIRST) && (idx <= irpd_pkg::CMD_LAST);
    addr_off = irpd_pkg::ADDR_LAST - idx;
    cmd_off  = irpd_pkg::CMD_LAST - idx;

    addr_d = addr_q;
    cmd_d  = cmd_q;
    if (in_addr) begin
      addr_d[addr_off[irpd_pkg::BitPosW-1:0]] = bit_one;
    end else if (in_cmd) begin
      cmd_d[cmd_off[irpd_pkg::BitPosW-1:0]] = bit_one;
    end

    done_d       = idx >= irpd_pkg::FRAME_LAST_EDGE;
    edge_index_d = done_d ? '0 : idx + irpd_pkg::IdxW'(1);
    cmd_out_d    = done_d ? cmd_d  : '0;
    addr_out_d   = done_d ? addr_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_index_q <= '0;
      addr_q       <= '0;
      cmd_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        edge_index_q <= edge_index_d;
        addr_q       <= addr_d;
        cmd_q        <= cmd_d;
        out_valid_q  <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      done_q     <= done_d;
      cmd_out_q  <= cmd_out_d;
      addr_out_q <= addr_out_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.frame_done     = done_q;
  assign result_o.command_code   = cmd_out_q;
  assign result_o.device_address = addr_out_q;

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_index_q <= irpd_pkg::FRAME_LAST_EDGE)
    else $error("edge index beyond last frame edge");

  a_done_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && done_d |=> edge_index_q == '0)
    else $error("edge index not restarted after frame done");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !done_q |-> cmd_out_q == '0 && addr_out_q == '0)
    else $error("nonzero code on a non-final edge");

  a_pending_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(interval_q))
    else $error("pending edge lost from input register");

endmodule

[design/ir_remote_pulse_distance_decoder_core.sv]
// NEC-style IR remote decoder. Each request on edge_i is one falling edge of the
// IR receiver with the timer ticks since the previous edge. An interval at or
// above gap_threshold (reg 0, addr 0x0, reset 3000) restarts edge counting. Edges
// 3..10 give address bits 7..0 and edges 19..26 give command bits 7..0; a bit is
// one when the low byte of the interval exceeds bit_threshold (reg 1, addr 0x4,
// reset 54). Every edge yields exactly one result request; at edge index 32
// of a frame, frame_done is 1 with command and address; else all fields are 0.
// Decoded bits are not cleared between frames, so a frame cut short by a gap can
// report bits left over from an earlier frame. Throughput is one edge per clock
// while results are taken when offered: an input register feeds a single pass
// of compare/select logic into the result register. A held result still lets
// one edge land in an empty input register; further edges wait until the result
// is taken. Write the thresholds only while no edge is in flight.
module ir_remote_pulse_distance_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  irpd_edge_if.sink                      edge_i,
  irpd_result_if.source                  result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [irpd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [irpd_pkg::ApbDataW-1:0]  pwdata,
  output logic [irpd_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  irpd_pkg::cfg_t cfg;

  // threshold registers on the APB port
  irpd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // edge counter, bit capture and result register
  irpd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .edge_i   (edge_i),
    .result_o (result_o)
  );

endmodule
